// ===== rtl/core/pcap_capture_buffer_writer_top_macros.svh =====
// Assertion macros shared by the pcap capture writer checkers.
// Each macro expands to one labeled concurrent assertion on a given clock and reset.
`ifndef PCAP_CAPTURE_BUFFER_WRITER_TOP_MACROS_SVH
`define PCAP_CAPTURE_BUFFER_WRITER_TOP_MACROS_SVH

// Same-cycle implication: when ante holds, cons must hold too.
`define PCAPW_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("pcap writer check failed");

// Next-cycle implication: when ante holds, cons must hold in the next cycle.
`define PCAPW_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("pcap writer check failed");

`endif

// ===== rtl/core/pcapw_pkg.sv =====
// Package for the pcap capture buffer writer: constants, field layout, register codes.
// No dependencies; used by the top level and its checker.
`timescale 1ns / 1ps

package pcapw_pkg;

   // Buffer and register defaults
   localparam int          BUF_BYTES_DEFAULT = 65536;
   localparam logic [15:0] SNAP_RESET        = 16'd4096;
   localparam logic [31:0] LINK_RESET        = 32'd105;

   // pcap file format constants
   localparam logic [31:0] PCAP_MAGIC       = 32'ha1b2c3d4;
   localparam logic [15:0] VERSION_MAJOR    = 16'd2;
   localparam logic [15:0] VERSION_MINOR    = 16'd4;
   localparam int          GLOBAL_HDR_BYTES = 24;
   localparam int          RECORD_HDR_BYTES = 16;

   // ts / 1e6 == (ts * RECIP_MAGIC) >> RECIP_SHIFT, exact for every 32-bit ts
   localparam logic [31:0] USEC_PER_SEC = 32'd1000000;
   localparam logic [31:0] RECIP_MAGIC  = 32'h431bde83;
   localparam int          RECIP_SHIFT  = 50;
   localparam int          SEC_W        = 13;   // seconds never exceed 4294

   // Byte positions inside one step's burst: global header, record header, payload
   localparam int          POS_W          = 6;
   localparam logic [5:0]  POS_GLOBAL     = 6'd0;
   localparam logic [5:0]  POS_GLOBAL_END = 6'd23;
   localparam logic [5:0]  POS_RECORD     = 6'd24;
   localparam logic [5:0]  POS_RECORD_END = 6'd39;
   localparam logic [5:0]  POS_PAYLOAD    = 6'd40;

   // Stream field layout
   localparam int REQ_DATA_W   = 56;
   localparam int RSP_DATA_W   = 32;
   localparam int ADDR_W       = 16;
   localparam int BYTE_W       = 8;
   localparam int RSP_ADDR_LSB = 0;
   localparam int RSP_DATA_LSB = 16;
   localparam int RSP_FULL_BIT = 24;

   // Register port
   localparam int CSR_ADDR_W  = 3;
   localparam int CSR_DATA_W  = 32;
   localparam int REG_SEL_BIT = 2;

   typedef enum logic {
      REG_SNAP_LENGTH = 1'b0,
      REG_LINK_TYPE   = 1'b1
   } reg_sel_type;

endpackage

// ===== rtl/core/pcap_capture_buffer_writer_top.sv =====
// Channel    | dir | handshake             | payload
// req_       | in  | tvalid/tready         | tdata: pkt_byte, pkt_len, timestamp_us; tuser: first
// rsp_       | out | tvalid/tready, tlast  | tdata: wr_addr, wr_data, capture_full
// csr_       | in  | psel/penable/pwrite   | snap_length at 0x0, link_type at 0x4
//
// Results leave one byte per cycle, while rsp_ does not stall, through a single output
// register. A payload byte writes itself, a dropped byte nothing. A packet's first byte
// waits for the seconds/microseconds split, then writes 16 header bytes and one payload
// byte; for the very first packet the 24-byte global header comes first, with no wait.
// Reset is synchronous; the block is ready for items as soon as reset drops.
// A stalled rsp_ holds the current burst; req_ is taken again on its final byte.
`timescale 1ns / 1ps

module pcap_capture_buffer_writer_top #(
   parameter int BUF_BYTES = pcapw_pkg::BUF_BYTES_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   // input items
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [pcapw_pkg::REQ_DATA_W-1:0] req_tdata,   // pkt_byte[7:0], pkt_len[23:8],
                                                         // timestamp_us[55:24]
   input  logic                             req_tuser,   // first_of_packet
   // buffer writes
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [pcapw_pkg::RSP_DATA_W-1:0] rsp_tdata,   // wr_addr[15:0], wr_data[23:16],
                                                         // capture_full[24], zero above
   output logic                             rsp_tlast,   // last
   // register port
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [pcapw_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [pcapw_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [pcapw_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                             csr_pready
);

   import pcapw_pkg::*;

   // write index must hold BUF_BYTES itself; fit check needs room for index + 16 + 65535
   localparam int IDX_W = $clog2(BUF_BYTES) + 1;
   localparam int CHK_W = ((IDX_W > ADDR_W) ? IDX_W : ADDR_W) + 2;

   // configuration registers
   logic [15:0]      snap_length_ff;
   logic [31:0]      link_type_ff;
   logic             csr_write;
   reg_sel_type      csr_sel;

   // capture state
   logic [IDX_W-1:0] write_index_ff, write_index_in;
   logic             header_written_ff, header_written_in;
   logic             full_latched_ff, full_latched_in;
   logic [15:0]      payload_left_ff, payload_left_in;

   // input fields
   logic [7:0]       pkt_byte;
   logic [15:0]      pkt_len;
   logic [31:0]      timestamp_us;
   logic             first_of_packet;

   // per-item decision
   logic             req_accept;
   logic             first_go, put_global, put_record, put_payload, fits, job_start;
   logic [15:0]      kept_len, left_open;
   logic [IDX_W-1:0] idx_hdr;
   logic [POS_W-1:0] start_pos, end_pos;

   // burst sequencer
   logic             job_active_ff, job_active_in;
   logic             prep_ff, prep_in;
   logic [POS_W-1:0] pos_ff, pos_in;
   logic [POS_W-1:0] end_ff;
   logic [15:0]      addr_ff, addr_in;
   logic             job_full_ff;
   logic [7:0]       job_byte_ff;
   logic [15:0]      job_incl_ff, job_len_ff;
   logic [31:0]      job_ts_ff;
   logic             out_free, emit, job_done;

   // seconds / microseconds split
   logic [63:0]      prod_in, prod_ff;
   logic [SEC_W-1:0] sec_in, sec_ff;
   logic [31:0]      secm_in, secm_ff;
   logic [31:0]      usec;

   // byte selection
   logic [31:0]      word_sel;
   logic [7:0]       byte_sel;

   // output register
   logic             rsp_valid_ff, rsp_valid_in;
   logic [15:0]      rsp_addr_ff;
   logic [7:0]       rsp_data_ff;
   logic             rsp_full_ff;
   logic             rsp_last_ff;

   // ---------------------------------------------------------------- register port
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_sel    = reg_sel_type'(csr_paddr[REG_SEL_BIT]);

   always_comb begin
      unique case (csr_sel)
         REG_SNAP_LENGTH: csr_prdata = {16'd0, snap_length_ff};
         REG_LINK_TYPE:   csr_prdata = link_type_ff;
      endcase
   end

   // ---------------------------------------------------------------- input fields
   assign pkt_byte        = req_tdata[7:0];
   assign pkt_len         = req_tdata[23:8];
   assign timestamp_us    = req_tdata[55:24];
   assign first_of_packet = req_tuser;

   // ---------------------------------------------------------------- item decision
   // Everything a step changes in the capture state is settled at the transfer;
   // the burst it causes is then played out by the sequencer.
   always_comb begin
      first_go   = first_of_packet && !full_latched_ff;
      put_global = first_go && !header_written_ff;
      kept_len   = (pkt_len < snap_length_ff) ? pkt_len : snap_length_ff;
      idx_hdr    = write_index_ff + (put_global ? IDX_W'(GLOBAL_HDR_BYTES) : '0);
      fits       = (CHK_W'(idx_hdr) + CHK_W'(RECORD_HDR_BYTES) + CHK_W'(kept_len))
                   <= CHK_W'(BUF_BYTES);
      put_record = first_go && fits;

      full_latched_in   = full_latched_ff || (first_go && !fits);
      header_written_in = header_written_ff || put_global;

      // a new first byte abandons any record still open
      left_open   = first_go ? (put_record ? kept_len : 16'd0) : payload_left_ff;
      put_payload = !full_latched_in && (left_open != 16'd0);
      payload_left_in = put_payload ? (left_open - 16'd1) : left_open;

      write_index_in = idx_hdr
                     + (put_record ? IDX_W'(RECORD_HDR_BYTES) : '0)
                     + (put_payload ? IDX_W'(1) : '0);

      job_start = put_global || put_record || put_payload;
      start_pos = put_global ? POS_GLOBAL : (put_record ? POS_RECORD : POS_PAYLOAD);
      end_pos   = put_payload ? POS_PAYLOAD : (put_record ? POS_RECORD_END : POS_GLOBAL_END);
   end

   // ---------------------------------------------------------------- handshakes
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign emit       = job_active_ff && !prep_ff && out_free;
   assign job_done   = emit && (pos_ff == end_ff);
   assign req_tready = !reset && (!job_active_ff || job_done);
   assign req_accept = req_tvalid && req_tready;

   // ---------------------------------------------------------------- sequencer next state
   always_comb begin
      job_active_in = job_active_ff;
      pos_in        = pos_ff;
      addr_in       = addr_ff;
      prep_in       = 1'b0;
      if (emit) begin
         pos_in  = pos_ff + POS_W'(1);
         addr_in = addr_ff + 16'd1;
         if (job_done) begin
            job_active_in = 1'b0;
         end
      end
      if (req_accept) begin
         job_active_in = job_start;
         pos_in        = start_pos;
         addr_in       = 16'(write_index_ff);
         // record header right away: hold the burst while the seconds split is registered
         prep_in       = put_record && !put_global;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // ---------------------------------------------------------------- seconds split
   assign prod_in = 64'(timestamp_us) * 64'(RECIP_MAGIC);
   assign sec_in  = prod_ff[RECIP_SHIFT +: SEC_W];
   assign secm_in = 32'(sec_in) * USEC_PER_SEC;
   assign usec    = job_ts_ff - secm_ff;

   // ---------------------------------------------------------------- byte select
   // Burst positions in 32-bit words: magic, version, zone, sigfigs, snaplen, link,
   // seconds, microseconds, included length, original length, then the payload byte.
   always_comb begin
      case (pos_ff[POS_W-1:2])
         4'd0:    word_sel = PCAP_MAGIC;
         4'd1:    word_sel = {VERSION_MINOR, VERSION_MAJOR};
         4'd4:    word_sel = {16'd0, snap_length_ff};
         4'd5:    word_sel = link_type_ff;
         4'd6:    word_sel = 32'(sec_ff);
         4'd7:    word_sel = usec;
         4'd8:    word_sel = {16'd0, job_incl_ff};
         4'd9:    word_sel = {16'd0, job_len_ff};
         4'd10:   word_sel = {24'd0, job_byte_ff};
         default: word_sel = 32'd0;
      endcase
      byte_sel = word_sel[pos_ff[1:0]*BYTE_W +: BYTE_W];
   end

   // ---------------------------------------------------------------- control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         snap_length_ff    <= SNAP_RESET;
         link_type_ff      <= LINK_RESET;
         write_index_ff    <= '0;
         header_written_ff <= 1'b0;
         full_latched_ff   <= 1'b0;
         payload_left_ff   <= '0;
         job_active_ff     <= 1'b0;
         prep_ff           <= 1'b0;
         rsp_valid_ff      <= 1'b0;
      end else begin
         if (csr_write) begin
            unique case (csr_sel)
               REG_SNAP_LENGTH: snap_length_ff <= csr_pwdata[15:0];
               REG_LINK_TYPE:   link_type_ff   <= csr_pwdata;
            endcase
         end
         if (req_accept) begin
            write_index_ff    <= write_index_in;
            header_written_ff <= header_written_in;
            full_latched_ff   <= full_latched_in;
            payload_left_ff   <= payload_left_in;
         end
         job_active_ff <= job_active_in;
         prep_ff       <= prep_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // ---------------------------------------------------------------- datapath registers
   always_ff @(posedge clock) begin
      pos_ff  <= pos_in;
      addr_ff <= addr_in;
      sec_ff  <= sec_in;
      secm_ff <= secm_in;
      if (req_accept) begin
         end_ff      <= end_pos;
         job_full_ff <= full_latched_in;
         job_byte_ff <= pkt_byte;
         job_incl_ff <= kept_len;
         job_len_ff  <= pkt_len;
         job_ts_ff   <= timestamp_us;
         prod_ff     <= prod_in;
      end
      if (emit) begin
         rsp_addr_ff <= addr_ff;
         rsp_data_ff <= byte_sel;
         rsp_full_ff <= job_full_ff;
         rsp_last_ff <= job_done;
      end
   end

   // ---------------------------------------------------------------- outputs
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tdata  = {7'd0, rsp_full_ff, rsp_data_ff, rsp_addr_ff};

endmodule

// ===== rtl/core/pcapw_checker.sv =====
// Port-level checker for the pcap capture buffer writer, bound to the top level.
// Depends on pcapw_pkg and pcap_capture_buffer_writer_top_macros.svh.
`timescale 1ns / 1ps
`include "pcap_capture_buffer_writer_top_macros.svh"

module pcapw_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             rsp_tvalid,
   input logic                             rsp_tready,
   input logic [pcapw_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input logic                             rsp_tlast
);

   import pcapw_pkg::*;

   logic              out_xfer;
   logic [ADDR_W-1:0] out_addr;
   logic              seen_ff, seen_in;
   logic              full_seen_ff, full_seen_in;
   logic [ADDR_W-1:0] next_addr_ff;

   assign out_xfer = rsp_tvalid && rsp_tready;
   assign out_addr = rsp_tdata[RSP_ADDR_LSB +: ADDR_W];

   // track the last written offset and whether the capture stopped
   assign seen_in      = seen_ff || out_xfer;
   assign full_seen_in = full_seen_ff || (out_xfer && rsp_tlast && rsp_tdata[RSP_FULL_BIT]);

   always_ff @(posedge clock) begin
      if (reset) begin
         seen_ff      <= 1'b0;
         full_seen_ff <= 1'b0;
      end else begin
         seen_ff      <= seen_in;
         full_seen_ff <= full_seen_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_xfer) begin
         next_addr_ff <= out_addr + ADDR_W'(1);
      end
   end

   // the file image starts at offset zero
   `PCAPW_ASSERT_IMPLY(a_first_addr_zero, clock, reset, !seen_ff && rsp_tvalid, out_addr == '0)

   // buffer offsets advance by one with every transfer
   `PCAPW_ASSERT_IMPLY(a_addr_sequential, clock, reset,
                       seen_ff && rsp_tvalid, out_addr == next_addr_ff)

   // once a step ends with the buffer full, nothing more is written
   `PCAPW_ASSERT_IMPLY(a_silent_after_full, clock, reset, full_seen_ff, !rsp_tvalid)

   // a stalled write keeps its contents
   `PCAPW_ASSERT_NEXT(a_stall_holds, clock, reset, rsp_tvalid && !rsp_tready,
                      rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))

endmodule

bind pcap_capture_buffer_writer_top pcapw_checker u_pcapw_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);
